// ===== design/vcr_pkg.sv =====
// vcr_pkg: constants and helpers for the voice channel repack block.
// Holds the whitening sequence, field widths and the whitening bit lookup.
// No dependencies.
package vcr_pkg;

    localparam int unsigned WORD_W    = 49;
    localparam int unsigned CH_W      = 104;
    localparam int unsigned CH_HI_W   = 40;
    localparam int unsigned CH_LO_W   = 64;
    localparam int unsigned TRIPLED   = 27;
    localparam int unsigned PLAIN_N   = 22;
    localparam int unsigned PLAIN_ST  = 81;
    localparam int unsigned ILV_ROWS  = 4;
    localparam int unsigned ILV_COLS  = 26;

    // request codes
    typedef enum logic {
        CMD_ENCODE = 1'b0,
        CMD_DECODE = 1'b1
    } t_cmd;

    // whitening bytes, sent MSB first
    localparam logic [7:0] WHITEN_SEQ [13] = '{
        8'h93, 8'hD7, 8'h51, 8'h21, 8'h9C, 8'h2F, 8'h6C,
        8'hD0, 8'hEF, 8'h0F, 8'hF8, 8'h3D, 8'hF1
    };

    // whitening bit for channel bit idx (0..103)
    function automatic logic whiten_bit(input logic [6:0] idx);
        logic [7:0] byte_v;
        byte_v = WHITEN_SEQ[idx[6:3]];
        return byte_v[3'd7 - idx[2:0]];
    endfunction

endpackage

// ===== design/vcr_if.sv =====
// vcr_if: valid/ready channel interfaces for the voice channel repack block.
// Request side carries the command and both payloads; result side the outputs.
// Depends on vcr_pkg for field widths.
interface vcr_in_if import vcr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 command;
    logic [WORD_W-1:0]    vocoder_word;
    logic [CH_HI_W-1:0]   channel_in_high;
    logic [CH_LO_W-1:0]   channel_in_low;

    modport source (output valid, command, vocoder_word, channel_in_high,
                    channel_in_low, input ready);
    modport sink   (input valid, command, vocoder_word, channel_in_high,
                    channel_in_low, output ready);
endinterface

interface vcr_out_if import vcr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [WORD_W-1:0]    vocoder_out;
    logic [CH_HI_W-1:0]   channel_out_high;
    logic [CH_LO_W-1:0]   channel_out_low;

    modport source (output valid, vocoder_out, channel_out_high, channel_out_low,
                    input ready);
    modport sink   (input valid, vocoder_out, channel_out_high, channel_out_low,
                    output ready);
endinterface

// ===== design/vcr_encoder.sv =====
// vcr_encoder: vocoder word to 104-bit interleaved, whitened voice channel.
// Purely combinational wiring and constant XOR. Depends on vcr_pkg.
module vcr_encoder import vcr_pkg::*; (
    input  logic [WORD_W-1:0] i_word,
    output logic [CH_W-1:0]   o_stream
);

    logic [CH_W-1:0] vch;

    always_comb begin
        // tripled leading bits, plain tail, bit 103 zero
        vch = '0;
        for (int k = 0; k < TRIPLED; k++) begin
            vch[3*k]     = i_word[WORD_W-1-k];
            vch[3*k + 1] = i_word[WORD_W-1-k];
            vch[3*k + 2] = i_word[WORD_W-1-k];
        end
        for (int k = 0; k < PLAIN_N; k++) begin
            vch[PLAIN_ST + k] = i_word[PLAIN_N-1-k];
        end

        // whiten and interleave 26 by 4; stream bit n sits at o_stream[103-n]
        o_stream = '0;
        for (int r = 0; r < ILV_ROWS; r++) begin
            for (int c = 0; c < ILV_COLS; c++) begin
                o_stream[CH_W-1-(c*ILV_ROWS + r)] =
                    vch[r*ILV_COLS + c] ^ whiten_bit(7'(r*ILV_COLS + c));
            end
        end
    end

endmodule

// ===== design/vcr_decoder.sv =====
// vcr_decoder: 104-bit voice channel back to the 49-bit vocoder word.
// Undoes interleave and whitening, keeps the middle copy of each triple.
// Depends on vcr_pkg.
module vcr_decoder import vcr_pkg::*; (
    input  logic [CH_W-1:0]   i_stream,
    output logic [WORD_W-1:0] o_word
);

    logic [CH_W-1:0] vch;

    always_comb begin
        // de-interleave and de-whiten
        vch = '0;
        for (int r = 0; r < ILV_ROWS; r++) begin
            for (int c = 0; c < ILV_COLS; c++) begin
                vch[r*ILV_COLS + c] = i_stream[CH_W-1-(c*ILV_ROWS + r)]
                    ^ whiten_bit(7'(r*ILV_COLS + c));
            end
        end

        // middle copy of each triple, then the plain tail
        o_word = '0;
        for (int k = 0; k < TRIPLED; k++) begin
            o_word[WORD_W-1-k] = vch[3*k + 1];
        end
        for (int k = 0; k < PLAIN_N; k++) begin
            o_word[PLAIN_N-1-k] = vch[PLAIN_ST + k];
        end
    end

endmodule

// ===== design/voice_channel_repack_core.sv =====
// Voice channel repack core: converts one voice frame per request between a
// 49-bit vocoder word and a 104-bit voice channel (tripled leading bits,
// whitening, 26 by 4 interleave), in either direction as the command selects.
// A new request is accepted every clock unless the pipe is full and stalled;
// each request passes the input register, then the result register, and a
// stalled result holds the pipe while one further request can wait in the
// input register. The unused result field is driven to zero.
module voice_channel_repack_core import vcr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vcr_in_if.sink      i_in,
    vcr_out_if.source   o_out
);

    // input register
    logic                r_in_valid;
    logic                r_cmd;
    logic [WORD_W-1:0]   r_word;
    logic [CH_W-1:0]     r_stream;

    // result register
    logic                r_out_valid;
    logic [WORD_W-1:0]   r_vocoder;
    logic [CH_HI_W-1:0]  r_ch_hi;
    logic [CH_LO_W-1:0]  r_ch_lo;

    logic                advance;
    logic                in_take;
    logic [CH_W-1:0]     enc_stream;
    logic [WORD_W-1:0]   dec_word;

    // pipe moves when the result slot is empty or being taken
    assign advance    = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || advance;
    assign in_take    = i_in.valid && i_in.ready;

    vcr_encoder u_enc (
        .i_word   (r_word),
        .o_stream (enc_stream)
    );

    vcr_decoder u_dec (
        .i_stream (r_stream),
        .o_word   (dec_word)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // payload capture
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd    <= i_in.command;
            r_word   <= i_in.vocoder_word;
            r_stream <= {i_in.channel_in_high, i_in.channel_in_low};
        end
        if (advance) begin
            if (r_cmd == CMD_DECODE) begin
                r_vocoder <= dec_word;
                r_ch_hi   <= '0;
                r_ch_lo   <= '0;
            end else begin
                r_vocoder <= '0;
                r_ch_hi   <= enc_stream[CH_W-1:CH_LO_W];
                r_ch_lo   <= enc_stream[CH_LO_W-1:0];
            end
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.vocoder_out      = r_vocoder;
    assign o_out.channel_out_high = r_ch_hi;
    assign o_out.channel_out_low  = r_ch_lo;

endmodule
